@@ hdl/pfba_pkg.sv @@
// Shared types and constants for the page frame bitmap allocator.
`default_nettype none

package pfba_pkg;

    // Map word geometry: one bit per page, read a word at a time
    localparam int WORD_W = 32;
    localparam int LOG_W  = 5;

    // Internal page index width, wide enough for any 15-bit page total
    localparam int PAGE_W = 16;
    localparam int WIDX_W = PAGE_W - LOG_W;

    // Field widths
    localparam int FIELD_W    = 15;
    localparam int ADDR_W     = 26;
    localparam int PAGE_SHIFT = 12;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 2'd1;

    // Register reset values
    localparam logic [FIELD_W-1:0] TOTAL_RESET    = 15'd16384;
    localparam logic [FIELD_W-1:0] RESERVED_RESET = FIELD_W'(32'h00b0_0000 / 32'h1000);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clear;      // write one zero word of the clearing pass
        logic load;       // capture a request and the register snapshot
        logic scan;       // run the first-fit search pass
        logic upd_start;  // rewind for the mark and recount pass
        logic update;     // run the mark and recount pass
        logic out_load;   // load the result register
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clr_last;   // clearing pass is at its last word
        logic scan_done;  // search ended, with or without a hit
        logic upd_done;   // mark and recount pass ended
    } sts_t;

endpackage

`default_nettype wire

@@ hdl/pfba_ctrl.sv @@
// Controller state machine for the page frame bitmap allocator.
`default_nettype none

module pfba_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  wire logic          out_stall,
    input  wire pfba_pkg::sts_t sts,
    output pfba_pkg::cmd_t     cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // Decode commands and the next state
    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    cmd.upd_start = 1'b1;
                    state_next    = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                if (sts.upd_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // Hold the finished request until the result register frees up
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and the result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

@@ hdl/pfba_dp.sv @@
// Datapath of the page frame bitmap allocator: used map, search and recount.
`default_nettype none

module pfba_dp #(
    parameter int MAX_PAGES = 16384
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire pfba_pkg::cmd_t                    cmd,
    output pfba_pkg::sts_t                         sts,
    input  wire logic [pfba_pkg::FIELD_W-1:0]      page_count,
    input  wire logic                              cfg_we,
    input  wire logic [pfba_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [pfba_pkg::FIELD_W-1:0]      cfg_data,
    output logic                                   granted,
    output logic [pfba_pkg::ADDR_W-1:0]            start_address,
    output logic [pfba_pkg::FIELD_W-1:0]           free_left
);

    localparam int WORD_W    = pfba_pkg::WORD_W;
    localparam int LOG_W     = pfba_pkg::LOG_W;
    localparam int PAGE_W    = pfba_pkg::PAGE_W;
    localparam int WIDX_W    = pfba_pkg::WIDX_W;
    localparam int FIELD_W   = pfba_pkg::FIELD_W;
    localparam int ADDR_W    = pfba_pkg::ADDR_W;
    localparam int NUM_WORDS = (MAX_PAGES + WORD_W - 1) / WORD_W;
    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int CAP_INT   = (MAX_PAGES > 32767) ? 32767 : MAX_PAGES;
    localparam logic [PAGE_W-1:0] LIM_CAP  = PAGE_W'(CAP_INT);
    localparam logic [AW-1:0]     LAST_CLR = AW'(NUM_WORDS - 1);
    localparam int PG_ADDR_W = ADDR_W - pfba_pkg::PAGE_SHIFT;

    // Used map
    logic [WORD_W-1:0] mem [NUM_WORDS];
    logic [WORD_W-1:0] rdata_reg;

    // Configuration registers
    logic [FIELD_W-1:0] total_reg;
    logic [FIELD_W-1:0] reserved_reg;

    // Request context
    logic [FIELD_W-1:0] n_reg;
    logic [PAGE_W-1:0]  lim_reg;
    logic [PAGE_W-1:0]  res_reg;
    logic               rng_reg;
    logic [WIDX_W-1:0]  last_w_reg;

    // Word pipeline
    logic               iss_reg;
    logic [WIDX_W-1:0]  rd_ptr_reg;
    logic               pv_reg;
    logic [WIDX_W-1:0]  pw_reg;
    logic [AW-1:0]      clr_ptr_reg;

    // Search and count results
    logic [PAGE_W-1:0]  run_reg;
    logic               hit_reg;
    logic [PAGE_W-1:0]  start_reg;
    logic [PAGE_W-1:0]  end_reg;
    logic [PAGE_W-1:0]  cnt_reg;

    // Result register
    logic               granted_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [FIELD_W-1:0] free_reg;

    // Snapshot of the current register settings
    logic [PAGE_W-1:0]  total_ext;
    logic [PAGE_W-1:0]  lim_cfg;
    logic [PAGE_W-1:0]  res_cfg;
    logic [PAGE_W-1:0]  lim_m1;
    logic               rng_cfg;

    // Per-word logic
    logic [PAGE_W-1:0]  base_pg;
    logic [WORD_W-1:0]  in_rng;
    logic [WORD_W-1:0]  mark_v;
    logic [WORD_W-1:0]  used_v;
    logic [WORD_W-1:0]  hit_v;
    logic [WORD_W-1:0]  new_word;
    logic [WORD_W-1:0]  free_v;
    logic [PAGE_W-1:0]  run_out;
    logic [LOG_W-1:0]   hit_idx;
    logic [PAGE_W-1:0]  hit_pg;
    logic [1:0]         pc1 [16];
    logic [2:0]         pc2 [8];
    logic [3:0]         pc3 [4];
    logic [4:0]         pc4 [2];
    logic [5:0]         pop;

    logic               issue;
    logic               scan_go;
    logic               upd_go;
    logic               hit_now;

    assign total_ext = PAGE_W'(total_reg);
    assign lim_cfg   = (total_ext > LIM_CAP) ? LIM_CAP : total_ext;
    assign res_cfg   = PAGE_W'(reserved_reg);
    assign rng_cfg   = (res_cfg < lim_cfg);
    assign lim_m1    = lim_cfg - PAGE_W'(1);

    assign base_pg = {pw_reg, {LOG_W{1'b0}}};

    // Classify each page of the word in flight
    always_comb
    begin : classify
        logic [PAGE_W-1:0] pg;
        for (int j = 0; j < WORD_W; j++)
        begin
            pg        = base_pg + PAGE_W'(j);
            in_rng[j] = (pg >= res_reg) && (pg < lim_reg);
            mark_v[j] = hit_reg && (pg >= start_reg) && (pg < end_reg);
        end
    end

    assign used_v   = rdata_reg | ~in_rng;
    assign new_word = rdata_reg | mark_v;
    assign free_v   = ~new_word & in_rng;

    // Free run length ending at each bit, carried in from earlier words
    always_comb
    begin : run_len
        logic              found;
        logic [LOG_W-1:0]  upos;
        logic [PAGE_W-1:0] run_j;
        run_out = run_reg;
        hit_v   = '0;
        for (int j = 0; j < WORD_W; j++)
        begin
            found = 1'b0;
            upos  = '0;
            for (int k = 0; k <= j; k++)
            begin
                if (used_v[k])
                begin
                    found = 1'b1;
                    upos  = LOG_W'(k);
                end
            end
            if (found)
            begin
                run_j = PAGE_W'(LOG_W'(j) - upos);
            end
            else
            begin
                run_j = run_reg + PAGE_W'(j + 1);
            end
            hit_v[j] = (run_j >= PAGE_W'(n_reg));
            if (j == WORD_W - 1)
            begin
                run_out = run_j;
            end
        end
    end

    // Pick the lowest bit where a run reaches the requested length
    always_comb
    begin
        hit_idx = '0;
        for (int j = WORD_W - 1; j >= 0; j--)
        begin
            if (hit_v[j])
            begin
                hit_idx = LOG_W'(j);
            end
        end
    end

    assign hit_pg = base_pg + PAGE_W'(hit_idx);

    // Count free pages of the updated word with an adder tree
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            pc1[i] = 2'(free_v[2*i]) + 2'(free_v[2*i+1]);
        end
        for (int i = 0; i < 8; i++)
        begin
            pc2[i] = 3'(pc1[2*i]) + 3'(pc1[2*i+1]);
        end
        for (int i = 0; i < 4; i++)
        begin
            pc3[i] = 4'(pc2[2*i]) + 4'(pc2[2*i+1]);
        end
        for (int i = 0; i < 2; i++)
        begin
            pc4[i] = 5'(pc3[2*i]) + 5'(pc3[2*i+1]);
        end
        pop = 6'(pc4[0]) + 6'(pc4[1]);
    end

    assign scan_go = cmd.scan && pv_reg;
    assign upd_go  = cmd.update && pv_reg;
    assign hit_now = scan_go && (|hit_v);
    assign issue   = iss_reg && (cmd.scan || cmd.update) && !hit_now;

    assign sts.clr_last  = (clr_ptr_reg == LAST_CLR);
    assign sts.scan_done = hit_now || (!iss_reg && !pv_reg);
    assign sts.upd_done  = !iss_reg && !pv_reg;

    // Write the map during clearing and update, read one word per issue
    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            mem[clr_ptr_reg] <= '0;
        end
        else if (upd_go)
        begin
            mem[AW'(pw_reg)] <= new_word;
        end
        if (issue)
        begin
            rdata_reg <= mem[AW'(rd_ptr_reg)];
        end
    end

    // Hold the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg    <= pfba_pkg::TOTAL_RESET;
            reserved_reg <= pfba_pkg::RESERVED_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pfba_pkg::CFG_TOTAL:    total_reg    <= cfg_data;
                pfba_pkg::CFG_RESERVED: reserved_reg <= cfg_data;
                default:                ;
            endcase
        end
    end

    // Sequence the word pipeline and the search state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_ptr_reg <= '0;
            iss_reg     <= 1'b0;
            rd_ptr_reg  <= '0;
            pv_reg      <= 1'b0;
            pw_reg      <= '0;
            run_reg     <= '0;
            hit_reg     <= 1'b0;
            start_reg   <= '0;
            end_reg     <= '0;
            cnt_reg     <= '0;
            n_reg       <= '0;
            lim_reg     <= '0;
            res_reg     <= '0;
            rng_reg     <= 1'b0;
            last_w_reg  <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_ptr_reg <= clr_ptr_reg + AW'(1);
            end

            // Advance the read pointer; no read is issued on load or rewind
            pv_reg <= issue;
            if (issue)
            begin
                pw_reg     <= rd_ptr_reg;
                rd_ptr_reg <= rd_ptr_reg + WIDX_W'(1);
                if (rd_ptr_reg == last_w_reg)
                begin
                    iss_reg <= 1'b0;
                end
            end

            // Carry the run and capture the first fit; the rewind follows at once
            if (scan_go)
            begin
                run_reg <= run_out;
            end
            if (hit_now)
            begin
                hit_reg   <= 1'b1;
                start_reg <= hit_pg + PAGE_W'(1) - PAGE_W'(n_reg);
                end_reg   <= hit_pg + PAGE_W'(1);
            end

            // Rewind for the mark and recount pass
            if (cmd.upd_start)
            begin
                rd_ptr_reg <= res_reg[PAGE_W-1:LOG_W];
                iss_reg    <= rng_reg;
                cnt_reg    <= '0;
            end
            if (upd_go)
            begin
                cnt_reg <= cnt_reg + PAGE_W'(pop);
            end

            // Capture a new request
            if (cmd.load)
            begin
                n_reg      <= page_count;
                lim_reg    <= lim_cfg;
                res_reg    <= res_cfg;
                rng_reg    <= rng_cfg;
                last_w_reg <= lim_m1[PAGE_W-1:LOG_W];
                rd_ptr_reg <= res_cfg[PAGE_W-1:LOG_W];
                iss_reg    <= rng_cfg && (page_count != '0);
                run_reg    <= '0;
                hit_reg    <= 1'b0;
            end
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            granted_reg <= hit_reg;
            addr_reg    <= hit_reg ? {start_reg[PG_ADDR_W-1:0], {pfba_pkg::PAGE_SHIFT{1'b0}}}
                                   : '0;
            free_reg    <= cnt_reg[FIELD_W-1:0];
        end
    end

    assign granted       = granted_reg;
    assign start_address = addr_reg;
    assign free_left     = free_reg;

endmodule

`default_nettype wire

@@ hdl/page_frame_bitmap_allocator_top.sv @@
// Top level of the page frame bitmap allocator.
//
// Usage: a request carries page_count on the input channel (in_valid/in_stall)
// and is taken when in_valid is high and in_stall is low. Each request gives
// one result on the output channel (out_valid/out_stall): granted, the byte
// address of the first page of the lowest fitting run (zero on failure) and
// the free page count left in [reserved, total), total capped at MAX_PAGES.
// Registers are written through cfg_valid/cfg_ready/cfg_index/cfg_data;
// cfg_ready is always high. Timing: one request at a time. A request walks
// the used map a 32-bit word a cycle through one memory read port, twice: a
// first-fit search up to the hit and a mark-and-recount pass over the words
// from reserved to total. The next request can be taken once the result
// register has loaded.
// Reset: the map is cleared one word a cycle, all ceil(MAX_PAGES/32) words
// (512 at the default); in_stall stays high meanwhile, register writes are
// still taken. A stalled result is held in the output register; the next
// request is still taken and its result waits until the register frees up.
`default_nettype none

module page_frame_bitmap_allocator_top #(
    parameter int MAX_PAGES = 16384
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [pfba_pkg::FIELD_W-1:0]    page_count,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic                                 granted,
    output logic [pfba_pkg::ADDR_W-1:0]          start_address,
    output logic [pfba_pkg::FIELD_W-1:0]         free_left,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [pfba_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pfba_pkg::FIELD_W-1:0]    cfg_data
);

    pfba_pkg::cmd_t cmd;
    pfba_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    pfba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    pfba_dp #(
        .MAX_PAGES (MAX_PAGES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .page_count    (page_count),
        .cfg_we        (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .granted       (granted),
        .start_address (start_address),
        .free_left     (free_left)
    );

endmodule

`default_nettype wire

@@ hdl/pfba_checker.sv @@
// Port-level checks for the page frame bitmap allocator, bound to the top level.
`default_nettype none

module pfba_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            in_valid,
    input wire logic                            in_stall,
    input wire logic                            out_valid,
    input wire logic                            out_stall,
    input wire logic                            granted,
    input wire logic [pfba_pkg::ADDR_W-1:0]     start_address,
    input wire logic [pfba_pkg::FIELD_W-1:0]    free_left
);

    // A stalled result stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=>
            out_valid && $stable({granted, start_address, free_left}))
        else $error("stalled result changed or dropped");

    // A failed request reports a zero address
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !granted |-> start_address == '0)
        else $error("failed request with nonzero address");

    // A granted address is page aligned
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && granted |-> start_address[11:0] == 12'd0)
        else $error("granted address not page aligned");

    // An accepted request makes the block busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request taken back to back");

endmodule

bind page_frame_bitmap_allocator_top pfba_checker u_pfba_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .granted       (granted),
    .start_address (start_address),
    .free_left     (free_left)
);

`default_nettype wire
